// ===== sv/a2p_pkg.sv =====
// ----------------------------------------------------------------------------
// a2p_pkg
// Constants and types for the polynomial atan2 unit.
// ----------------------------------------------------------------------------
package a2p_pkg;

  localparam int INPUT_WIDTH_DEFAULT = 16;

  // Q16 polynomial coefficients
  localparam int COEF_C3 = 3047;
  localparam int COEF_C2 = 10441;
  localparam int COEF_C1 = 21471;

  // Q16 reflection constants
  localparam int Q16_HALF_PI = 102944;
  localparam int Q16_PI      = 205887;

  localparam int ANGLE_WIDTH = 16;
  localparam int RATIO_WIDTH = 17;
  localparam int RATIO_FRAC  = 16;

  typedef struct packed {
    logic sneg;
    logic cneg;
    logic swap;
    logic zero;
  } a2p_flags_t;

endpackage

// ===== sv/atan2_polynomial_unit.sv =====
// ----------------------------------------------------------------------------
// atan2_polynomial_unit
// Four-quadrant arctangent, Q2.13 radians, via a pipelined restoring divider
// and an odd seventh-order polynomial.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the restoring divider retires one quotient
// bit per stage (17 stages) and each polynomial multiply has its own stage.
// A stall at the output holds the whole pipeline in place.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module atan2_polynomial_unit #(
  parameter int INPUT_WIDTH = a2p_pkg::INPUT_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic signed [INPUT_WIDTH-1:0]       sine_value,
  input  logic signed [INPUT_WIDTH-1:0]       cosine_value,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [a2p_pkg::ANGLE_WIDTH-1:0] angle,
  output logic                                both_zero
);

  localparam int W    = INPUT_WIDTH;
  localparam int QW   = a2p_pkg::RATIO_WIDTH;
  localparam int DIVN = QW;
  localparam int NST  = DIVN + 12;
  localparam int RW   = 20;

  function automatic logic signed [39:0] rnd_s(input logic signed [39:0] x, input int n);
    logic signed [39:0] half;
    half = 40'sd1 <<< (n - 1);
    if (x < 0) begin
      return -(((-x) + half) >>> n);
    end
    return (x + half) >>> n;
  endfunction

  logic            en;
  logic [NST-1:0]  v;

  assign en           = !v[NST-1] || result_ready;
  assign sample_ready = en;
  assign result_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], sample_valid};
    end
  end

  // flags travel with every stage
  a2p_pkg::a2p_flags_t fl [0:NST-1];

  // front end: magnitudes and ordering
  logic [W-1:0] abs_s, abs_c;
  a2p_pkg::a2p_flags_t fl_next;

  always_comb begin
    abs_s        = sine_value[W-1]   ? W'(~sine_value + 1'b1)   : W'(sine_value);
    abs_c        = cosine_value[W-1] ? W'(~cosine_value + 1'b1) : W'(cosine_value);
    fl_next.sneg = sine_value[W-1];
    fl_next.cneg = cosine_value[W-1];
    fl_next.swap = abs_s > abs_c;
    fl_next.zero = (abs_s == '0) && (abs_c == '0);
  end

  logic [W:0]    rem [0:DIVN];
  logic [W-1:0]  dmx [0:DIVN];
  logic [QW-1:0] quo [0:DIVN];

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0]  <= fl_next;
      rem[0] <= (abs_s < abs_c) ? {1'b0, abs_s} : {1'b0, abs_c};
      dmx[0] <= (abs_s < abs_c) ? abs_c : abs_s;
      quo[0] <= '0;
      for (int k = 1; k < NST; k++) begin
        fl[k] <= fl[k-1];
      end
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar j = 0; j < DIVN; j++) begin : g_div
    logic [W:0] trial;
    logic       qbit;
    always_comb begin
      trial = (j == 0) ? rem[j] : {rem[j][W-1:0], 1'b0};
      qbit  = trial >= {1'b0, dmx[j]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= qbit ? (trial - {1'b0, dmx[j]}) : trial;
        dmx[j+1] <= dmx[j];
        quo[j+1] <= {quo[j][QW-2:0], qbit};
      end
    end
  end

  // polynomial stages
  logic [QW-1:0]        a_p1, a_p2, a_p3, a_p4, a_p5, a_p6, a_p7, a_p8;
  logic [QW-1:0]        sv_p1, sv_p2, sv_p3, sv_p4, sv_p5;
  logic [29:0]          m1;
  logic [13:0]          t1;
  logic [30:0]          m2;
  logic signed [15:0]   t2;
  logic signed [33:0]   m3;
  logic signed [17:0]   t3;
  logic signed [35:0]   m4;
  logic signed [RW-1:0] r, r_ref;
  logic signed [a2p_pkg::ANGLE_WIDTH-1:0] angle_q;
  logic                 zero_q;

  logic [33:0]          sq;
  logic [14:0]          m2_rnd;
  logic signed [RW-1:0] r1, r2, r3;

  always_comb begin
    sq     = 34'({17'd0, quo[DIVN]} * {17'd0, quo[DIVN]}) + 34'd32768;
    m2_rnd = 15'((m2 + 31'd32768) >> 16);
    r1     = fl[NST-3].swap ? (RW'(a2p_pkg::Q16_HALF_PI) - r) : r;
    r2     = fl[NST-3].cneg ? (RW'(a2p_pkg::Q16_PI) - r1) : r1;
    r3     = fl[NST-3].sneg ? -r2 : r2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p1  <= quo[DIVN];
      sv_p1 <= sq[32:16];
      a_p2  <= a_p1;
      sv_p2 <= sv_p1;
      m1    <= 30'(a2p_pkg::COEF_C3) * {13'd0, sv_p1};
      a_p3  <= a_p2;
      sv_p3 <= sv_p2;
      t1    <= 14'(a2p_pkg::COEF_C2) - 14'((m1 + 30'd32768) >> 16);
      a_p4  <= a_p3;
      sv_p4 <= sv_p3;
      m2    <= {17'd0, t1} * {14'd0, sv_p3};
      a_p5  <= a_p4;
      sv_p5 <= sv_p4;
      t2    <= $signed({1'b0, m2_rnd}) - 16'(a2p_pkg::COEF_C1);
      a_p6  <= a_p5;
      m3    <= 34'(t2) * 34'($signed({1'b0, sv_p5}));
      a_p7  <= a_p6;
      t3    <= 18'(rnd_s(40'(m3), a2p_pkg::RATIO_FRAC));
      a_p8  <= a_p7;
      m4    <= 36'(t3) * 36'($signed({1'b0, a_p7}));
      r     <= RW'($signed({1'b0, a_p8})) + RW'(rnd_s(40'(m4), a2p_pkg::RATIO_FRAC));
      r_ref <= r3;
      zero_q  <= fl[NST-2].zero;
      angle_q <= fl[NST-2].zero ? '0 :
                 a2p_pkg::ANGLE_WIDTH'(rnd_s(40'(r_ref), 3));
    end
  end

  assign angle     = angle_q;
  assign both_zero = zero_q;

endmodule
